/* rtl/core/tsac_pkg.sv */
`timescale 1ns / 1ps

package tsac_pkg;

  // Connection state codes as seen on conn_state.
  localparam logic [3:0] ST_CLOSED   = 4'd0;
  localparam logic [3:0] ST_SYN_SENT = 4'd1;
  localparam logic [3:0] ST_SYN_RCVD = 4'd2;
  localparam logic [3:0] ST_ESTAB    = 4'd3;

  // Kind of reset segment requested.
  localparam logic [1:0] RK_NONE    = 2'd0;
  localparam logic [1:0] RK_SEQ_ACK = 2'd1;
  localparam logic [1:0] RK_ACK_LEN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOCAL_ISS     = 2'd0;
  localparam logic [1:0] CFG_START_PASSIVE = 2'd1;
  localparam logic [1:0] CFG_PEER_ISS      = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] seg_len;
    logic        length_ok;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_rst;
    logic [31:0] send_next;
    logic [31:0] recv_window;
    logic        synack_ok;
  } seg_t;

  typedef struct packed {
    logic        drop;
    logic        send_ack;
    logic [1:0]  rst_kind;
    logic [31:0] rst_seq;
    logic [31:0] rst_ack;
    logic        send_synack;
    logic        ack_advanced;
    logic [31:0] acked_upto;
    logic        conn_failed;
    logic [3:0]  conn_state;
    logic [15:0] send_window;
  } result_t;

  // Per-connection control block.
  typedef struct packed {
    logic [3:0]  state_code;
    logic [31:0] recv_next;
    logic [31:0] send_unacked;
    logic [15:0] peer_wnd;
    logic [31:0] wnd_update_seq;
    logic [31:0] wnd_update_ack;
  } conn_t;

  // Sequence space compares, modulo 2^32.
  function automatic logic sq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic sq_le(input logic [31:0] a, input logic [31:0] b);
    return (a == b) || sq_lt(a, b);
  endfunction

  function automatic logic in_window(input logic [31:0] rnxt, input logic [31:0] s,
                                     input logic [31:0] wnd);
    logic [31:0] edge_hi;
    edge_hi = rnxt + wnd;
    return sq_le(rnxt, s) && sq_lt(s, edge_hi);
  endfunction

  // Four-case segment acceptability test.
  function automatic logic acceptable(input logic [31:0] rnxt, input logic [15:0] len,
                                      input logic [31:0] seq, input logic [31:0] wnd);
    logic [31:0] last;
    last = seq + {16'd0, len} - 32'd1;
    if (len == 16'd0) begin
      return (wnd == 32'd0) ? (seq == rnxt) : in_window(rnxt, seq, wnd);
    end
    if (wnd == 32'd0) begin
      return 1'b0;
    end
    return in_window(rnxt, seq, wnd) || in_window(rnxt, last, wnd);
  endfunction

  // Fresh control block from the configuration registers.
  function automatic conn_t conn_restart(input logic [31:0] liss, input logic passive,
                                         input logic [31:0] piss);
    conn_t c;
    c.state_code     = passive ? ST_SYN_RCVD : ST_SYN_SENT;
    c.recv_next      = piss + 32'd1;
    c.send_unacked   = liss;
    c.peer_wnd       = 16'd0;
    c.wnd_update_seq = 32'd0;
    c.wnd_update_ack = 32'd0;
    return c;
  endfunction

endpackage

/* rtl/core/tsac_if.sv */
`timescale 1ns / 1ps

// Segment header channel.
interface tsac_seg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [15:0] peer_window;
  logic [15:0] seg_len;
  logic        length_ok;
  logic        flag_syn;
  logic        flag_ack;
  logic        flag_rst;
  logic [31:0] send_next;
  logic [31:0] recv_window;
  logic        synack_ok;

  modport source (
    output valid, seq_number, ack_number, peer_window, seg_len, length_ok,
           flag_syn, flag_ack, flag_rst, send_next, recv_window, synack_ok,
    input  ready
  );
  modport sink (
    input  valid, seq_number, ack_number, peer_window, seg_len, length_ok,
           flag_syn, flag_ack, flag_rst, send_next, recv_window, synack_ok,
    output ready
  );
endinterface

// Check result channel.
interface tsac_res_if;
  logic        valid;
  logic        ready;
  logic        drop;
  logic        send_ack;
  logic [1:0]  rst_kind;
  logic [31:0] rst_seq;
  logic [31:0] rst_ack;
  logic        send_synack;
  logic        ack_advanced;
  logic [31:0] acked_upto;
  logic        conn_failed;
  logic [3:0]  conn_state;
  logic [15:0] send_window;

  modport source (
    output valid, drop, send_ack, rst_kind, rst_seq, rst_ack, send_synack,
           ack_advanced, acked_upto, conn_failed, conn_state, send_window,
    input  ready
  );
  modport sink (
    input  valid, drop, send_ack, rst_kind, rst_seq, rst_ack, send_synack,
           ack_advanced, acked_upto, conn_failed, conn_state, send_window,
    output ready
  );
endinterface

/* rtl/core/tsac_eval.sv */
`timescale 1ns / 1ps

// Segment arrival rules for one header against the current control block.
module tsac_eval
  import tsac_pkg::*;
(
  input  seg_t        seg,
  input  conn_t       conn,
  input  logic [31:0] local_iss,
  output conn_t       conn_next,
  output result_t     res
);

  logic        drop;
  logic        do_ack;
  logic [1:0]  rkind;
  logic [31:0] rseq;
  logic [31:0] rack;
  logic        synack;
  logic        adv;
  logic        failed;
  logic [31:0] seq_end;
  logic [31:0] una_syn;
  logic        ack_in_range;

  assign seq_end      = seg.seq_number + {16'd0, seg.seg_len};
  assign una_syn      = seg.flag_ack ? seg.ack_number : conn.send_unacked;
  assign ack_in_range = sq_le(conn.send_unacked, seg.ack_number) &&
                        sq_le(seg.ack_number, seg.send_next);

  always_comb begin
    conn_next = conn;
    drop      = 1'b0;
    do_ack    = 1'b0;
    rkind     = RK_NONE;
    rseq      = 32'd0;
    rack      = 32'd0;
    synack    = 1'b0;
    adv       = 1'b0;
    failed    = 1'b0;

    priority if (!seg.length_ok) begin
      drop = 1'b1;
    end else if (conn.state_code == ST_CLOSED) begin
      drop = 1'b1;
    end else if (conn.state_code == ST_SYN_SENT) begin
      priority if (seg.flag_ack && (sq_le(seg.ack_number, local_iss) ||
                                    sq_lt(seg.send_next, seg.ack_number))) begin
        if (!seg.flag_rst) begin
          rkind = RK_ACK_LEN;
          rack  = seq_end;
        end
        drop = 1'b1;
      end else if (seg.flag_rst) begin
        if (seg.flag_ack && ack_in_range) begin
          failed               = 1'b1;
          conn_next.state_code = ST_CLOSED;
        end
        drop = 1'b1;
      end else if (!seg.flag_syn) begin
        drop = 1'b1;
      end else begin
        conn_next.recv_next    = seg.seq_number + 32'd1;
        conn_next.send_unacked = una_syn;
        adv                    = seg.flag_ack;
        if (sq_lt(local_iss, una_syn)) begin
          do_ack               = 1'b1;
          conn_next.state_code = ST_ESTAB;
        end else begin
          synack = 1'b1;
          if (seg.synack_ok) begin
            conn_next.state_code = ST_SYN_RCVD;
          end else begin
            drop = 1'b1;
          end
        end
      end
    end else if (!acceptable(conn.recv_next, seg.seg_len, seg.seq_number,
                             seg.recv_window)) begin
      do_ack = !seg.flag_rst;
      drop   = 1'b1;
    end else if (seg.flag_rst) begin
      failed               = 1'b1;
      conn_next.state_code = ST_CLOSED;
      drop                 = 1'b1;
    end else if (seg.flag_syn) begin
      if (seg.flag_ack) begin
        rkind = RK_SEQ_ACK;
        rseq  = seg.ack_number;
      end else begin
        rkind = RK_ACK_LEN;
        rack  = seq_end;
      end
      failed               = 1'b1;
      conn_next.state_code = ST_CLOSED;
      drop                 = 1'b1;
    end else if (!seg.flag_ack) begin
      drop = 1'b1;
    end else if (conn.state_code == ST_SYN_RCVD && !ack_in_range) begin
      rkind = RK_SEQ_ACK;
      rseq  = seg.ack_number;
      drop  = 1'b1;
    end else begin
      if (conn.state_code == ST_SYN_RCVD) begin
        conn_next.state_code = ST_ESTAB;
      end
      if (sq_lt(conn.send_unacked, seg.ack_number) &&
          sq_le(seg.ack_number, seg.send_next)) begin
        conn_next.send_unacked = seg.ack_number;
        adv                    = 1'b1;
        if (sq_lt(conn.wnd_update_seq, seg.seq_number) ||
            (conn.wnd_update_seq == seg.seq_number &&
             sq_le(conn.wnd_update_ack, seg.ack_number))) begin
          conn_next.peer_wnd       = seg.peer_window;
          conn_next.wnd_update_seq = seg.seq_number;
          conn_next.wnd_update_ack = seg.ack_number;
        end
      end else if (sq_lt(seg.send_next, seg.ack_number)) begin
        do_ack = 1'b1;
        drop   = 1'b1;
      end
    end
  end

  always_comb begin
    res.drop         = drop;
    res.send_ack     = do_ack;
    res.rst_kind     = rkind;
    res.rst_seq      = rseq;
    res.rst_ack      = rack;
    res.send_synack  = synack;
    res.ack_advanced = adv;
    res.acked_upto   = conn_next.send_unacked;
    res.conn_failed  = failed;
    res.conn_state   = conn_next.state_code;
    res.send_window  = conn_next.peer_wnd;
  end

endmodule

/* rtl/core/tcp_segment_arrival_check.sv */
`timescale 1ns / 1ps

// Receive-side control check of one TCP connection. Each item on seg is a parsed
// segment header together with the transmit side's current SND.NXT and the local
// receive window; each accepted item yields exactly one item on res, in order.
// The block takes one item per clock cycle while res is ready. The header is
// captured in an input register, the arrival rules are evaluated against the
// connection control block, and the result is held in an output register, from
// which it is presented on res, while the control block is updated in the same
// edge. That single evaluate-and-update step is what sets the rate, since each
// segment sees the state left by the one before it. Writing any of the
// configuration registers (local ISS, passive start, peer ISS) restarts the
// connection from those values; writes are meant to happen only while no item is
// in flight. Indexes beyond the register list are ignored.
module tcp_segment_arrival_check
  import tsac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tsac_seg_if.sink              seg,
  tsac_res_if.source            res
);

  // Configuration registers.
  logic [31:0] local_iss;
  logic        start_passive;
  logic [31:0] peer_iss;
  logic [31:0] local_iss_next;
  logic        start_passive_next;
  logic [31:0] peer_iss_next;
  logic        cfg_hit;

  // Input register stage.
  logic        in_valid;
  seg_t        in_item;
  seg_t        seg_item;

  // Connection control block and result register.
  conn_t       conn;
  conn_t       conn_eval;
  result_t     res_eval;
  logic        out_valid;
  result_t     out_item;

  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || res.ready;
  assign advance  = in_valid && out_free;
  assign seg.ready = !in_valid || out_free;

  always_comb begin
    seg_item.seq_number  = seg.seq_number;
    seg_item.ack_number  = seg.ack_number;
    seg_item.peer_window = seg.peer_window;
    seg_item.seg_len     = seg.seg_len;
    seg_item.length_ok   = seg.length_ok;
    seg_item.flag_syn    = seg.flag_syn;
    seg_item.flag_ack    = seg.flag_ack;
    seg_item.flag_rst    = seg.flag_rst;
    seg_item.send_next   = seg.send_next;
    seg_item.recv_window = seg.recv_window;
    seg_item.synack_ok   = seg.synack_ok;
  end

  // A write to a known index updates that register; the restart below uses the
  // freshly written value.
  always_comb begin
    local_iss_next     = local_iss;
    start_passive_next = start_passive;
    peer_iss_next      = peer_iss;
    cfg_hit            = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_ISS: begin
          local_iss_next = cfg_wdata[31:0];
          cfg_hit        = 1'b1;
        end
        CFG_START_PASSIVE: begin
          start_passive_next = cfg_wdata[0];
          cfg_hit            = 1'b1;
        end
        CFG_PEER_ISS: begin
          peer_iss_next = cfg_wdata[31:0];
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_iss     <= 32'd0;
      start_passive <= 1'b0;
      peer_iss      <= 32'd0;
    end else begin
      local_iss     <= local_iss_next;
      start_passive <= start_passive_next;
      peer_iss      <= peer_iss_next;
    end
  end

  tsac_eval u_eval (
    .seg       (in_item),
    .conn      (conn),
    .local_iss (local_iss),
    .conn_next (conn_eval),
    .res       (res_eval)
  );

  // Control block: restarted by reset or a configuration write to a known index,
  // otherwise updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      conn <= conn_restart(32'd0, 1'b0, 32'd0);
    end else if (cfg_hit) begin
      conn <= conn_restart(local_iss_next, start_passive_next, peer_iss_next);
    end else if (advance) begin
      conn <= conn_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (seg.ready) begin
        in_valid <= seg.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      in_item <= seg_item;
    end
    if (advance) begin
      out_item <= res_eval;
    end
  end

  assign res.valid        = out_valid;
  assign res.drop         = out_item.drop;
  assign res.send_ack     = out_item.send_ack;
  assign res.rst_kind     = out_item.rst_kind;
  assign res.rst_seq      = out_item.rst_seq;
  assign res.rst_ack      = out_item.rst_ack;
  assign res.send_synack  = out_item.send_synack;
  assign res.ack_advanced = out_item.ack_advanced;
  assign res.acked_upto   = out_item.acked_upto;
  assign res.conn_failed  = out_item.conn_failed;
  assign res.conn_state   = out_item.conn_state;
  assign res.send_window  = out_item.send_window;

endmodule

/* rtl/core/tsac_checker.sv */
`timescale 1ns / 1ps

module tsac_checker
  import tsac_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  rst_kind,
  input logic [31:0] rst_seq,
  input logic [31:0] rst_ack,
  input logic        conn_failed,
  input logic        drop,
  input logic [3:0]  conn_state
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A failed connection always reports closed and a dropped segment.
  a_fail_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && conn_failed |-> conn_state == ST_CLOSED && drop)
    else $error("failure without closed state");

  // Reset fields are zero unless a reset segment is requested.
  a_rst_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && rst_kind == RK_NONE |-> rst_seq == 32'd0 && rst_ack == 32'd0)
    else $error("reset fields set without a reset");

  // A reset segment is only generated for a segment that is discarded.
  a_rst_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rst_kind == RK_SEQ_ACK || rst_kind == RK_ACK_LEN) |-> drop)
    else $error("reset generated for kept segment");

endmodule

bind tcp_segment_arrival_check tsac_checker u_tsac_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .rst_kind    (res.rst_kind),
  .rst_seq     (res.rst_seq),
  .rst_ack     (res.rst_ack),
  .conn_failed (res.conn_failed),
  .drop        (res.drop),
  .conn_state  (res.conn_state)
);
